// File: hdl/dlru_pkg.sv
// ----------------------------------------------------------------------------
// dlru_pkg: shared types and constants of the LRU grant arbiter
// Transaction structs, operation, mode, status and register index codes.
// ----------------------------------------------------------------------------
package dlru_pkg;

  localparam int MACHINES = 32;
  localparam int IDX_W    = $clog2(MACHINES);
  localparam int CNT_W    = IDX_W + 1;
  localparam int STEP_W   = 32;

  localparam logic [STEP_W-1:0] STEP_MAX = 32'd2147483647;

  // operation codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SELECT = 2'd1;
  localparam logic [1:0] FUNC_RECORD = 2'd2;
  localparam logic [1:0] FUNC_DUMP   = 2'd3;

  // daemon modes
  localparam logic [1:0] MODE_CENTRAL     = 2'd0;
  localparam logic [1:0] MODE_DISTRIBUTED = 2'd1;
  localparam logic [1:0] MODE_SYNC        = 2'd2;
  localparam logic [1:0] MODE_RW          = 2'd3;

  // result status
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_ERR  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_ROUND_ROBIN = 2'd1;
  localparam logic [1:0] REG_MACHINES    = 2'd2;

  localparam int CFG_W = 6;

  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      privileges;
    logic [5:0]       capacity;
    logic [4:0]       machine;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [4:0]       granted;
    logic [31:0]      waiting_steps;
    logic             last;
  } out_item_t;

endpackage

// File: hdl/daemon_lru_arbiter_unit.sv
// ----------------------------------------------------------------------------
// daemon_lru_arbiter_unit: grant arbiter with least-recently-run selection
// Eligibility mask and run flags in flops, run stamps in a RAM with a registered read.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Load, record and every error or
// nothing-eligible answer goes through a response state to the output
// register. Select and the starvation dump scan the machines in use one
// entry per cycle while the output side does not stall, through the single
// read port of the stamp RAM. First-eligible select ends at the
// first eligible machine; a grant list ends at capacity or at the last
// eligible machine. Results leave through an output register.
module daemon_lru_arbiter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [dlru_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dlru_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dlru_pkg::out_item_t            out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RESP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  localparam logic [1:0] SCAN_DUMP  = 2'd0;
  localparam logic [1:0] SCAN_FIRST = 2'd1;
  localparam logic [1:0] SCAN_LRU   = 2'd2;
  localparam logic [1:0] SCAN_MULTI = 2'd3;

  localparam logic [dlru_pkg::CNT_W-1:0] N_MAX = dlru_pkg::CNT_W'(dlru_pkg::MACHINES);
  localparam logic [dlru_pkg::MACHINES:0] ONE_WIDE = (dlru_pkg::MACHINES+1)'(1);

  // configuration
  logic [1:0]                     daemon_mode;
  logic                           round_robin;
  logic [5:0]                     machines_in_use;

  // state
  logic [dlru_pkg::MACHINES-1:0]  eligible;
  logic [dlru_pkg::MACHINES-1:0]  ran_before;
  logic [dlru_pkg::STEP_W-1:0]    step_counter;
  logic [dlru_pkg::STEP_W-1:0]    stamp_mem [dlru_pkg::MACHINES];
  logic [dlru_pkg::STEP_W-1:0]    rd_data;

  // control
  logic [1:0]                     state;
  logic [1:0]                     resp_status;
  logic [1:0]                     scan_op;
  logic [dlru_pkg::IDX_W-1:0]     idx;
  logic [dlru_pkg::CNT_W-1:0]     cnt;
  logic [dlru_pkg::CNT_W-1:0]     cap_eff;
  logic                           have;
  logic [dlru_pkg::IDX_W-1:0]     best;
  logic                           best_never;
  logic [dlru_pkg::STEP_W-1:0]    best_stamp;

  // combinational
  logic [dlru_pkg::CNT_W-1:0]     n_used;
  logic [dlru_pkg::MACHINES-1:0]  used_mask;
  logic [dlru_pkg::MACHINES-1:0]  above_mask;
  logic                           accept;
  logic                           adv;
  logic                           step;
  logic [dlru_pkg::IDX_W-1:0]     rd_addr;
  logic                           rec_we;
  logic                           e_bit;
  logic                           r_bit;
  logic                           at_end;
  logic                           rest;
  logic                           rr_take;
  logic                           last_grant;
  logic                           emit;
  logic                           done;
  logic                           out_load;
  dlru_pkg::out_item_t            scan_out;

  assign n_used     = (machines_in_use > N_MAX) ? N_MAX : machines_in_use;
  assign used_mask  = dlru_pkg::MACHINES'((ONE_WIDE << n_used) - ONE_WIDE);
  assign above_mask = {{(dlru_pkg::MACHINES-1){1'b1}}, 1'b0} << idx;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign adv      = !out_valid || out_ready;
  assign step     = (state == ST_SCAN) && adv;

  // hold the address while stalled so rd_data stays with idx
  assign rd_addr = (state != ST_SCAN) ? '0 : (step ? idx + 1'b1 : idx);

  assign rec_we = accept && (in_data.func == dlru_pkg::FUNC_RECORD) &&
                  ({1'b0, in_data.machine} < n_used);

  always_comb begin
    e_bit      = eligible[idx];
    r_bit      = ran_before[idx];
    at_end     = (({1'b0, idx} + 1'b1) == n_used);
    rest       = |(eligible & used_mask & above_mask);
    // never-run beats any stamp; ties keep the lower index
    rr_take    = e_bit && (!have || (!best_never && (!r_bit || rd_data < best_stamp)));
    last_grant = ((cnt + 1'b1) == cap_eff) || at_end || !rest;
    scan_out.status        = dlru_pkg::STAT_OK;
    scan_out.granted       = idx;
    scan_out.waiting_steps = '0;
    scan_out.last          = 1'b1;
    emit = 1'b0;
    done = 1'b0;
    unique case (scan_op)
      SCAN_DUMP: begin
        emit = 1'b1;
        done = at_end;
        scan_out.waiting_steps = r_bit ? step_counter - rd_data : step_counter;
        scan_out.last          = at_end;
      end
      SCAN_FIRST: begin
        emit = e_bit;
        done = e_bit || at_end;
      end
      SCAN_LRU: begin
        emit = at_end;
        done = at_end;
        scan_out.granted = rr_take ? idx : best;
      end
      SCAN_MULTI: begin
        emit = e_bit;
        done = (e_bit && last_grant) || at_end;
        scan_out.last = last_grant;
      end
      default: begin
        emit = 1'b0;
        done = 1'b1;
      end
    endcase
  end

  assign out_load = ((state == ST_RESP) && adv) || (step && emit);

  // stamp RAM
  always_ff @(posedge clk) begin
    if (rec_we) begin
      stamp_mem[in_data.machine] <= step_counter;
    end
    rd_data <= stamp_mem[rd_addr];
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      daemon_mode     <= dlru_pkg::MODE_CENTRAL;
      round_robin     <= 1'b0;
      machines_in_use <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlru_pkg::REG_MODE:        daemon_mode     <= cfg_data[1:0];
        dlru_pkg::REG_ROUND_ROBIN: round_robin     <= cfg_data[0];
        dlru_pkg::REG_MACHINES:    machines_in_use <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      eligible     <= '0;
      ran_before   <= '0;
      step_counter <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            idx  <= '0;
            cnt  <= '0;
            have <= 1'b0;
            unique case (in_data.func)
              dlru_pkg::FUNC_LOAD: begin
                eligible    <= (eligible & ~used_mask) | (in_data.privileges & used_mask);
                resp_status <= dlru_pkg::STAT_OK;
                state       <= ST_RESP;
              end
              dlru_pkg::FUNC_SELECT: begin
                cap_eff <= (in_data.capacity > N_MAX) ? N_MAX : in_data.capacity;
                if (in_data.capacity == '0) begin
                  resp_status <= dlru_pkg::STAT_ERR;
                  state       <= ST_RESP;
                end else if ((eligible & used_mask) == '0) begin
                  resp_status <= dlru_pkg::STAT_NONE;
                  state       <= ST_RESP;
                end else begin
                  if (daemon_mode == dlru_pkg::MODE_CENTRAL && round_robin) begin
                    scan_op <= SCAN_LRU;
                  end else if (daemon_mode == dlru_pkg::MODE_CENTRAL ||
                               daemon_mode == dlru_pkg::MODE_RW) begin
                    scan_op <= SCAN_FIRST;
                  end else begin
                    scan_op <= SCAN_MULTI;
                  end
                  state <= ST_SCAN;
                end
              end
              dlru_pkg::FUNC_RECORD: begin
                if (rec_we) begin
                  ran_before[in_data.machine] <= 1'b1;
                  if (step_counter < dlru_pkg::STEP_MAX) begin
                    step_counter <= step_counter + 1'b1;
                  end
                  resp_status <= dlru_pkg::STAT_OK;
                end else begin
                  resp_status <= dlru_pkg::STAT_ERR;
                end
                state <= ST_RESP;
              end
              dlru_pkg::FUNC_DUMP: begin
                scan_op <= SCAN_DUMP;
                // no machines in use: nothing to report
                state   <= (n_used == '0) ? ST_IDLE : ST_SCAN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_RESP: begin
          if (adv) begin
            out_data.status        <= resp_status;
            out_data.granted       <= '0;
            out_data.waiting_steps <= '0;
            out_data.last          <= 1'b1;
            state                  <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (scan_op == SCAN_LRU && rr_take) begin
              have       <= 1'b1;
              best       <= idx;
              best_never <= !r_bit;
              best_stamp <= rd_data;
            end
            if (emit) begin
              out_data  <= scan_out;
              cnt       <= cnt + 1'b1;
            end
            idx <= idx + 1'b1;
            if (done) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_step_sat: assert property (@(posedge clk) disable iff (rst)
    step_counter <= dlru_pkg::STEP_MAX)
    else $error("step counter beyond saturation value");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> {1'b0, idx} < n_used)
    else $error("scan index past machines in use");

  a_record_mark: assert property (@(posedge clk) disable iff (rst)
    rec_we |=> ran_before[$past(in_data.machine)])
    else $error("recorded machine not marked as run");

  a_grant_cap: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && scan_op == SCAN_MULTI |-> cnt < cap_eff)
    else $error("grant count reached capacity inside scan");

endmodule
